FILE: sv/drm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the dirty reachability marker.
// No dependencies; used by the top level.
package drm_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned NODE_W   = 6;
  localparam int unsigned CACHED_W = 32;
  localparam int unsigned OUTVER_W = 32;
  localparam int unsigned TOTAL_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_MARK      = 3'd0,
    OP_CLEAR_ONE = 3'd1,
    OP_CLEAR_ALL = 3'd2,
    OP_ADD_EDGE  = 3'd3,
    OP_DEL_EDGE  = 3'd4,
    OP_QUERY     = 3'd5
  } op_t;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_EDGE_RD = 8'b0000_0010,
    ST_EDGE_WR = 8'b0000_0100,
    ST_WALK_RD = 8'b0000_1000,
    ST_WALK_WB = 8'b0001_0000,
    ST_READ    = 8'b0010_0000,
    ST_RESP    = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

endpackage

FILE: sv/dirty_reachability_marker_unit.sv
`timescale 1ns / 1ps
// Dirty reachability marker: edge matrix and version table in RAM, dirty bits in flops.
// Most operations pass through read, response and done states; edge updates first read and
// write the edge row, and a mark walks each node it reaches, reading its edge row and
// updating its version. One operation at a time; the next transfer can be taken in the cycle
// after the result transfer. Reset clears the FSM, the dirty bits and, through per-entry valid
// bits, both RAM tables at once. Depends on drm_pkg and drm_ram.
module dirty_reachability_marker_unit #(
  parameter int unsigned NODE_COUNT   = 64,
  parameter int unsigned VERSION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [drm_pkg::OPCODE_W-1:0]  opcode,
  input  logic [drm_pkg::NODE_W-1:0]    node,
  input  logic [drm_pkg::NODE_W-1:0]    edge_target,
  input  logic [drm_pkg::CACHED_W-1:0]  held_version,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          dirty_flag,
  output logic [drm_pkg::OUTVER_W-1:0]  version,
  output logic                          cache_valid,
  output logic [drm_pkg::TOTAL_W-1:0]   dirty_total
);

  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam int unsigned CW = (VERSION_BITS > drm_pkg::CACHED_W) ? VERSION_BITS
                                                                   : drm_pkg::CACHED_W;

  drm_pkg::state_t state;
  logic [drm_pkg::OPCODE_W-1:0] op_r;
  logic [drm_pkg::NODE_W-1:0]   node_r;
  logic [drm_pkg::NODE_W-1:0]   tgt_r;
  logic [drm_pkg::CACHED_W-1:0] cached_r;
  logic                         node_ok;
  logic                         node_in_ok;
  logic                         tgt_in_ok;
  logic [AW-1:0]                node_idx;
  logic [AW-1:0]                tgt_idx;

  logic [NODE_COUNT-1:0] dirty;
  logic [drm_pkg::TOTAL_W-1:0] dirty_num;
  logic [NODE_COUNT-1:0] seen;
  logic [NODE_COUNT-1:0] pending;
  logic [AW-1:0]         cur;
  logic [AW-1:0]         pick;

  logic [NODE_COUNT-1:0] edge_valid;
  logic [NODE_COUNT-1:0] ver_valid;
  logic                  edge_rv;
  logic                  ver_rv;
  logic [AW-1:0]         raddr;
  logic [NODE_COUNT-1:0] edge_q;
  logic [NODE_COUNT-1:0] edge_row;
  logic [NODE_COUNT-1:0] fresh;
  logic [NODE_COUNT-1:0] tgt_bit;
  logic                  edge_we;
  logic [NODE_COUNT-1:0] edge_wdata;
  logic [VERSION_BITS-1:0] ver_q;
  logic [VERSION_BITS-1:0] ver_cur;
  logic                  ver_we;
  logic [CW-1:0]         ver_x;
  logic [CW-1:0]         cached_x;

  assign node_idx   = node_r[AW-1:0];
  assign tgt_idx    = tgt_r[AW-1:0];
  assign node_ok    = {1'b0, node_r} < (drm_pkg::NODE_W+1)'(NODE_COUNT);
  assign node_in_ok = {1'b0, node} < (drm_pkg::NODE_W+1)'(NODE_COUNT);
  assign tgt_in_ok  = {1'b0, edge_target} < (drm_pkg::NODE_W+1)'(NODE_COUNT);
  assign in_stall   = (state != drm_pkg::ST_IDLE);

  always_comb begin
    pick = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = AW'(i);
      end
    end
  end

  assign raddr    = (state == drm_pkg::ST_WALK_RD) ? pick : node_idx;
  assign edge_row = edge_rv ? edge_q : '0;
  assign ver_cur  = ver_rv ? ver_q : '0;
  assign fresh    = edge_row & ~seen;
  assign tgt_bit  = NODE_COUNT'(1) << tgt_idx;

  assign edge_we    = (state == drm_pkg::ST_EDGE_WR);
  assign edge_wdata = (op_r == drm_pkg::OP_ADD_EDGE) ? (edge_row | tgt_bit)
                                                      : (edge_row & ~tgt_bit);
  assign ver_we     = (state == drm_pkg::ST_WALK_WB);

  assign ver_x    = CW'(ver_cur);
  assign cached_x = CW'(cached_r);

  drm_ram #(.WIDTH(NODE_COUNT), .DEPTH(NODE_COUNT)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (node_idx),
    .wdata (edge_wdata),
    .raddr (raddr),
    .rdata (edge_q)
  );

  drm_ram #(.WIDTH(VERSION_BITS), .DEPTH(NODE_COUNT)) u_ver_ram (
    .clk   (clk),
    .we    (ver_we),
    .waddr (cur),
    .wdata (ver_cur + VERSION_BITS'(1)),
    .raddr (raddr),
    .rdata (ver_q)
  );

  always_ff @(posedge clk) begin
    edge_rv <= edge_valid[raddr];
    ver_rv  <= ver_valid[raddr];
    if (rst) begin
      state       <= drm_pkg::ST_IDLE;
      dirty       <= '0;
      dirty_num   <= '0;
      edge_valid  <= '0;
      ver_valid   <= '0;
      seen        <= '0;
      pending     <= '0;
      out_valid   <= 1'b0;
    end else begin
      unique case (state)
        drm_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_r     <= opcode;
            node_r   <= node;
            tgt_r    <= edge_target;
            cached_r <= held_version;
            if (opcode == drm_pkg::OP_CLEAR_ALL) begin
              dirty     <= '0;
              dirty_num <= '0;
              state     <= drm_pkg::ST_READ;
            end else if (node_in_ok && opcode == drm_pkg::OP_MARK) begin
              seen    <= NODE_COUNT'(1) << node[AW-1:0];
              pending <= NODE_COUNT'(1) << node[AW-1:0];
              state   <= drm_pkg::ST_WALK_RD;
            end else if (node_in_ok && opcode == drm_pkg::OP_CLEAR_ONE) begin
              if (dirty[node[AW-1:0]]) begin
                dirty[node[AW-1:0]] <= 1'b0;
                dirty_num           <= dirty_num - drm_pkg::TOTAL_W'(1);
              end
              state <= drm_pkg::ST_READ;
            end else if (node_in_ok && tgt_in_ok &&
                         (opcode == drm_pkg::OP_ADD_EDGE ||
                          opcode == drm_pkg::OP_DEL_EDGE)) begin
              state <= drm_pkg::ST_EDGE_RD;
            end else begin
              state <= drm_pkg::ST_READ;
            end
          end
        end
        drm_pkg::ST_EDGE_RD: begin
          state <= drm_pkg::ST_EDGE_WR;
        end
        drm_pkg::ST_EDGE_WR: begin
          edge_valid[node_idx] <= 1'b1;
          state                <= drm_pkg::ST_READ;
        end
        drm_pkg::ST_WALK_RD: begin
          if (pending == '0) begin
            state <= drm_pkg::ST_READ;
          end else begin
            pending[pick] <= 1'b0;
            cur           <= pick;
            state         <= drm_pkg::ST_WALK_WB;
          end
        end
        drm_pkg::ST_WALK_WB: begin
          seen           <= seen | fresh;
          pending        <= pending | fresh;
          ver_valid[cur] <= 1'b1;
          if (!dirty[cur]) begin
            dirty[cur] <= 1'b1;
            dirty_num  <= dirty_num + drm_pkg::TOTAL_W'(1);
          end
          state <= drm_pkg::ST_WALK_RD;
        end
        drm_pkg::ST_READ: begin
          state <= drm_pkg::ST_RESP;
        end
        drm_pkg::ST_RESP: begin
          dirty_flag  <= node_ok & dirty[node_idx];
          version     <= node_ok ? ver_x[drm_pkg::OUTVER_W-1:0] : '0;
          cache_valid <= node_ok & (ver_x == cached_x);
          dirty_total <= dirty_num;
          out_valid   <= 1'b1;
          state       <= drm_pkg::ST_DONE;
        end
        drm_pkg::ST_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= drm_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= drm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    dirty_num == drm_pkg::TOTAL_W'($countones(dirty)))
    else $error("dirty count differs from number of dirty bits");

  a_pending_seen: assert property (@(posedge clk) disable iff (rst)
    (pending & ~seen) == '0)
    else $error("pending node not in visited set");

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == drm_pkg::ST_DONE))
    else $error("result valid outside of done state");

  a_walk_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == drm_pkg::ST_WALK_WB) |=> dirty[$past(cur)])
    else $error("walked node not marked dirty");

endmodule

FILE: sv/drm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module drm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
